// ===== rtl/sti_pkg.sv =====
// Shared types and codes for the sorted table block.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 7;

    // request command codes (code 3 acts as search)
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH
    } t_op;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  entry_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture compare masks for the accepted beat
        logic apply;  // commit shift and write the result
        t_op  op;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/sti_ctrl.sv =====
// Sequencer for the sorted table: accept in S_IDLE, then execute in S_EXEC.
// Depends on sti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sti_ctrl
    import sti_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic                  o_busy,
    output logic                  o_done,
    output t_cmd                  o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_done;
    t_op    r_op;
    logic   w_accept;
    t_op    w_op;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_comb begin
        case (i_cmd)
            CMD_INSERT: w_op = OP_INSERT;
            CMD_DELETE: w_op = OP_DELETE;
            default:    w_op = OP_SEARCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_op    <= OP_SEARCH;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= w_op;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state == S_EXEC);
    assign o_done      = r_done;
    assign o_ctl.load  = w_accept;
    assign o_ctl.apply = (r_state == S_EXEC);
    assign o_ctl.op    = r_op;

endmodule

`default_nettype wire

// ===== rtl/sti_dpath.sv =====
// Entry cells, per-cell comparators, count, capacity register and result register.
// Depends on sti_pkg; driven by sti_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sti_dpath
    import sti_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_ctl,
    input  wire t_req             i_req,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    output t_rsp                  o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    logic signed [ELEM_BITS-1:0] r_entries [DEPTH];
    logic [CW-1:0]               r_count;
    logic [CAP_W-1:0]            r_capacity;

    // masks captured at accept
    logic [DEPTH-1:0]            r_gt;   // entry > value, or slot unused
    logic [DEPTH-1:0]            r_ge;   // used slot with entry >= value
    logic                        r_found;
    logic                        r_full;
    logic signed [ELEM_BITS-1:0] r_val;

    t_rsp                        r_rsp;

    logic signed [ELEM_BITS-1:0] w_val;
    logic [DEPTH-1:0]            w_gt;
    logic [DEPTH-1:0]            w_ge;
    logic [DEPTH-1:0]            w_eq;
    logic [LW-1:0]               w_limit;
    logic [LW-1:0]               w_cap_ext;
    logic [LW-1:0]               w_depth_ext;

    logic signed [ELEM_BITS-1:0] w_dn [DEPTH];  // neighbour below
    logic signed [ELEM_BITS-1:0] w_up [DEPTH];  // neighbour above
    logic [DEPTH-1:0]            w_gt_lo;
    logic [DEPTH-1:0]            w_ins_edge;
    logic [DEPTH-1:0]            w_ge_edge;
    logic [IW-1:0]               w_ins_pos;
    logic [IW-1:0]               w_ge_pos;
    logic                        w_ins_go;
    logic                        w_del_go;
    logic [CW-1:0]               n_count;
    t_rsp                        n_rsp;

    // sign-extend or wrap to the element width
    assign w_val = ELEM_BITS'(i_req.value);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            logic valid;
            valid   = (CW'(i) < r_count);
            w_gt[i] = !valid || (r_entries[i] > w_val);
            w_ge[i] = valid && (r_entries[i] >= w_val);
            w_eq[i] = valid && (r_entries[i] == w_val);
        end
    end

    assign w_cap_ext   = LW'(r_capacity);
    assign w_depth_ext = LW'(DEPTH);
    assign w_limit     = (w_cap_ext < w_depth_ext) ? w_cap_ext : w_depth_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_gt    <= w_gt;
            r_ge    <= w_ge;
            r_found <= |w_eq;
            r_full  <= (LW'(r_count) >= w_limit);
            r_val   <= w_val;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
        if (g == 0) begin : g_bot
            assign w_dn[g] = r_entries[g];
        end else begin : g_mid
            assign w_dn[g] = r_entries[g-1];
        end
        if (g == DEPTH - 1) begin : g_top
            assign w_up[g] = r_entries[g];
        end else begin : g_low
            assign w_up[g] = r_entries[g+1];
        end
    end

    // r_gt is a thermometer and r_ge one run, so the rising edge marks the position
    assign w_gt_lo    = {r_gt[DEPTH-2:0], 1'b0};
    assign w_ins_edge = r_gt & ~w_gt_lo;
    assign w_ge_edge  = r_ge & ~{r_ge[DEPTH-2:0], 1'b0};

    always_comb begin
        w_ins_pos = '0;
        w_ge_pos  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ins_edge[i]) w_ins_pos = w_ins_pos | IW'(i);
            if (w_ge_edge[i])  w_ge_pos  = w_ge_pos | IW'(i);
        end
    end

    assign w_ins_go = i_ctl.apply && (i_ctl.op == OP_INSERT) && !r_full;
    assign w_del_go = i_ctl.apply && (i_ctl.op == OP_DELETE) && r_found;

    always_comb begin
        n_count = r_count;
        if (w_ins_go) begin
            n_count = r_count + CW'(1);
        end else if (w_del_go) begin
            n_count = r_count - CW'(1);
        end

        n_rsp.entry_count = CNT_W'(n_count);
        if (i_ctl.op == OP_INSERT) begin
            n_rsp.status   = r_full ? ST_FULL : ST_OK;
            n_rsp.position = r_full ? '0 : POS_W'(w_ins_pos);
        end else begin
            n_rsp.status   = r_found ? ST_OK : ST_NOTFOUND;
            n_rsp.position = r_found ? POS_W'(w_ge_pos) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ins_go) begin
                if (w_gt_lo[i]) begin
                    r_entries[i] <= w_dn[i];
                end else if (r_gt[i]) begin
                    r_entries[i] <= r_val;
                end
            end else if (w_del_go && r_ge[i]) begin
                r_entries[i] <= w_up[i];
            end
        end
        if (i_ctl.apply) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= CAP_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_insert_delete_search.sv =====
// Sorted table of signed entries with insert, delete-first-match and search.
// Result: o_done and o_rsp are registered as the controller leaves its execute state.
// Requests do not overlap: a compare across all entry cells at accept,
// then a shift-and-write while busy is high; start is taken only while busy is low.
// Reset: count cleared, capacity set to 64, entry contents undefined until written.
// Receiver cannot stall; o_done is high for one cycle, o_rsp holds until replaced.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_insert_delete_search
    import sti_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int ELEM_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_done,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    t_cmd w_ctl;

    sti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_req.cmd),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctl   (w_ctl)
    );

    sti_dpath #(
        .DEPTH     (DEPTH),
        .ELEM_BITS (ELEM_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/sti_checker.sv =====
// Port-level checks for the sorted table, attached to the top level by bind.
// Depends on sti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sti_checker
    import sti_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    // an accepted beat raises busy, and busy falls again as o_done is raised
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_done)
        else $error("busy cycle not followed by result strobe");

    a_done_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status != ST_OK) |-> (o_rsp.position == '0))
        else $error("non-zero position on a failed request");

endmodule

bind sorted_table_insert_delete_search sti_checker u_sti_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire
